// File: src/fixed_partition_fit_allocator_defines.svh
// assertion macros for the fixed partition fit allocator
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is held
`define FPFA_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fpfa check failed");
// checked property, also active during reset
`define FPFA_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fpfa check failed");
`else
`define FPFA_ASSERT_RST(lbl, clk, rstn, prop)
`define FPFA_ASSERT_ANY(lbl, clk, prop)
`endif

`endif

// File: src/fpfa_pkg.sv
// shared types and codes of the fixed partition fit allocator
`default_nettype none

package fpfa_pkg;

    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int POLICY_W = 2;
    localparam int TDATA_W  = 24;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;
    // code with no meaning, never places
    localparam logic [POLICY_W-1:0] POLICY_NONE  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FLUSH  = 4'b0100,
        ST_COMMIT = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_addr;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/fpfa_ctrl.sv
// controller state machine of the fixed partition fit allocator
`default_nettype none

module fpfa_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire logic               in_command,
    output logic                    in_ready,
    output fpfa_pkg::ctrl_cmd_t     cmd,
    input  wire fpfa_pkg::dp_status_t status
);

    fpfa_pkg::state_t state_reg;
    fpfa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpfa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            fpfa_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_command == fpfa_pkg::CMD_LOAD) begin
                        cmd.load = 1'b1;
                    end else begin
                        cmd.scan_start = 1'b1;
                        state_next     = fpfa_pkg::ST_SCAN;
                    end
                end
            end
            fpfa_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (status.last_addr) begin
                    state_next = fpfa_pkg::ST_FLUSH;
                end
            end
            fpfa_pkg::ST_FLUSH: begin
                // last partition compared this cycle
                state_next = fpfa_pkg::ST_COMMIT;
            end
            fpfa_pkg::ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = fpfa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fpfa_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/fpfa_datapath.sv
// partition table, fit comparator and result register
`default_nettype none

module fpfa_datapath #(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [fpfa_pkg::POLICY_W-1:0]     cfg_wr_data,
    input  wire logic [fpfa_pkg::SLOT_W-1:0]       in_slot,
    input  wire logic [fpfa_pkg::AMOUNT_W-1:0]     in_amount,
    input  wire fpfa_pkg::ctrl_cmd_t               cmd,
    output fpfa_pkg::dp_status_t                   status,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_placed,
    output logic [fpfa_pkg::SLOT_W-1:0]            out_slot,
    output logic [fpfa_pkg::AMOUNT_W-1:0]          out_size
);

    localparam int IDX_W = $clog2(NUM_PARTITIONS);

    logic [SIZE_BITS-1:0]          size_mem [NUM_PARTITIONS];
    logic [NUM_PARTITIONS-1:0]     used_reg;
    logic [fpfa_pkg::POLICY_W-1:0] policy_reg;
    logic [SIZE_BITS-1:0]          amount_reg;
    logic [IDX_W-1:0]              scan_addr_reg;
    logic [SIZE_BITS-1:0]          rd_size_reg;
    logic                          rd_used_reg;
    logic [IDX_W-1:0]              cmp_idx_reg;
    logic                          cmp_valid_reg;
    logic                          found_reg;
    logic [IDX_W-1:0]              best_idx_reg;
    logic [SIZE_BITS-1:0]          best_size_reg;
    logic                          out_valid_reg;
    logic                          out_placed_reg;
    logic [fpfa_pkg::SLOT_W-1:0]   out_slot_reg;
    logic [fpfa_pkg::AMOUNT_W-1:0] out_size_reg;

    logic [31:0]          slot_wide;
    logic [31:0]          amount_wide;
    logic [31:0]          best_size_wide;
    logic [31:0]          best_idx_wide;
    logic                 slot_in_range;
    logic [IDX_W-1:0]     wr_idx;
    logic [SIZE_BITS-1:0] amount_sz;
    logic                 fits;
    logic                 take;
    logic                 out_free;

    assign slot_wide      = 32'(in_slot);
    assign amount_wide    = 32'(in_amount);
    assign best_size_wide = 32'(best_size_reg);
    assign best_idx_wide  = 32'(best_idx_reg);
    assign slot_in_range  = slot_wide < 32'(NUM_PARTITIONS);
    assign wr_idx         = slot_wide[IDX_W-1:0];
    assign amount_sz      = amount_wide[SIZE_BITS-1:0];

    assign out_free         = !out_valid_reg || out_ready;
    assign status.out_free  = out_free;
    assign status.last_addr = scan_addr_reg == IDX_W'(NUM_PARTITIONS - 1);

    // a used partition never fits; policy code three never places
    assign fits = cmp_valid_reg && !rd_used_reg && (rd_size_reg >= amount_reg)
                  && (policy_reg != fpfa_pkg::POLICY_NONE);

    always_comb begin
        take = 1'b0;
        if (fits) begin
            if (!found_reg) begin
                take = 1'b1;
            end else begin
                case (policy_reg)
                    fpfa_pkg::POLICY_BEST:  take = rd_size_reg < best_size_reg;
                    fpfa_pkg::POLICY_WORST: take = rd_size_reg > best_size_reg;
                    default:                take = 1'b0;
                endcase
            end
        end
    end

    // size table, no reset: an unloaded entry is read but never fits, as its used mark stays set
    always_ff @(posedge aclk) begin
        if (cmd.load && slot_in_range) begin
            size_mem[wr_idx] <= amount_sz;
        end
        if (cmd.scan_step) begin
            rd_size_reg <= size_mem[scan_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= '1;
            policy_reg    <= fpfa_pkg::POLICY_FIRST;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                policy_reg <= cfg_wr_data;
            end
            if (cmd.load && slot_in_range) begin
                used_reg[wr_idx] <= 1'b0;
            end
            if (cmd.commit && found_reg) begin
                used_reg[best_idx_reg] <= 1'b1;
            end
            cmp_valid_reg <= cmd.scan_step;
            if (cmd.scan_start) begin
                found_reg <= 1'b0;
            end else if (take) begin
                found_reg <= 1'b1;
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            amount_reg    <= amount_sz;
            scan_addr_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_addr_reg <= scan_addr_reg + 1'b1;
        end
        if (cmd.scan_step) begin
            rd_used_reg <= used_reg[scan_addr_reg];
            cmp_idx_reg <= scan_addr_reg;
        end
        if (take) begin
            best_idx_reg  <= cmp_idx_reg;
            best_size_reg <= rd_size_reg;
        end
        if (cmd.commit) begin
            out_placed_reg <= found_reg;
            out_slot_reg   <= found_reg ? best_idx_wide[fpfa_pkg::SLOT_W-1:0] : '0;
            out_size_reg   <= found_reg ? best_size_wide[fpfa_pkg::AMOUNT_W-1:0] : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_placed = out_placed_reg;
    assign out_slot   = out_slot_reg;
    assign out_size   = out_size_reg;

endmodule

`default_nettype wire

// File: src/fixed_partition_fit_allocator.sv
// top level of the fixed partition fit allocator
`default_nettype none

// Fixed partition allocator: a table of NUM_PARTITIONS partitions, each with a
// size and a used mark (all used after reset). A load transaction (tuser 0)
// writes one partition's size and frees it and gives no result; a slot at or
// beyond NUM_PARTITIONS is ignored. An allocate transaction (tuser 1) scans
// the table and takes the free partition that fits by fit_policy (0 first,
// 1 smallest, 2 largest; ties to the lowest index; 3 never places), marks it
// used and returns one result transaction. An allocate keeps the input side
// busy until it commits: the scan reads one entry per cycle through the size
// memory's single read port, then a flush step finishes the last compare and
// a commit step commits. The result sits in an output register, so loads are
// still taken while it waits; a further allocate waits in its commit step
// until the register is free. fit_policy is written through cfg_wr_en /
// cfg_wr_data; the user must write it only while idle (not enforced by the block).

`include "fixed_partition_fit_allocator_defines.svh"

module fixed_partition_fit_allocator #(
    parameter int NUM_PARTITIONS = 16,
    parameter int SIZE_BITS      = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration: fit_policy
    input  wire logic                             cfg_wr_en,
    input  wire logic [fpfa_pkg::POLICY_W-1:0]    cfg_wr_data,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [fpfa_pkg::TDATA_W-1:0]     s_tdata,  // slot[3:0], amount[19:4]
    input  wire logic                             s_tuser,  // command
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [fpfa_pkg::TDATA_W-1:0]          m_tdata,  // chosen_slot[3:0], chosen_size[19:4]
    output logic                                  m_tuser   // placed
);

    fpfa_pkg::ctrl_cmd_t  ctrl_cmd;
    fpfa_pkg::dp_status_t dp_status;

    logic                              in_ready;
    logic [fpfa_pkg::SLOT_W-1:0]       in_slot;
    logic [fpfa_pkg::AMOUNT_W-1:0]     in_amount;
    logic                              out_placed;
    logic [fpfa_pkg::SLOT_W-1:0]       out_slot;
    logic [fpfa_pkg::AMOUNT_W-1:0]     out_size;

    // unpack the input transaction
    assign in_slot   = s_tdata[fpfa_pkg::SLOT_W-1:0];
    assign in_amount = s_tdata[fpfa_pkg::SLOT_W +: fpfa_pkg::AMOUNT_W];
    assign s_tready  = in_ready;

    fpfa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .in_ready   (in_ready),
        .cmd        (ctrl_cmd),
        .status     (dp_status)
    );

    fpfa_datapath #(
        .NUM_PARTITIONS (NUM_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_slot     (in_slot),
        .in_amount   (in_amount),
        .cmd         (ctrl_cmd),
        .status      (dp_status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_placed  (out_placed),
        .out_slot    (out_slot),
        .out_size    (out_size)
    );

    // pack the result transaction, zero pad to whole bytes
    assign m_tdata = {
        (fpfa_pkg::TDATA_W - fpfa_pkg::SLOT_W - fpfa_pkg::AMOUNT_W)'(0),
        out_size,
        out_slot
    };
    assign m_tuser = out_placed;

    // no input taken while a scan is running
    `FPFA_ASSERT_RST(a_no_accept_in_scan, aclk, aresetn, ctrl_cmd.scan_step |-> !s_tready)
    // a commit never overwrites a result still waiting
    `FPFA_ASSERT_RST(a_commit_out_free, aclk, aresetn, ctrl_cmd.commit |-> (!m_tvalid || m_tready))
    // a new result only appears right after a commit
    `FPFA_ASSERT_RST(a_result_from_commit, aclk, aresetn, $rose(m_tvalid) |-> $past(ctrl_cmd.commit))
    // an unplaced result carries all zero fields
    `FPFA_ASSERT_ANY(a_unplaced_zero, aclk, (aresetn && m_tvalid && !m_tuser) |-> (m_tdata == '0))

endmodule

`default_nettype wire
